>>> rtl/core/simeck64_block_cipher_core_assert.svh
// ----------------------------------------------------------------------------
// Simeck64 core assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIMECK64_BLOCK_CIPHER_CORE_ASSERT_SVH
`define SIMECK64_BLOCK_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTH

// assertion disabled while the active-low reset is asserted
`define SIMECK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// assertion that also holds during reset
`define SIMECK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SIMECK_ASSERT(lbl, clk, rstn, prop, msg)

`define SIMECK_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/simeck64_pkg.sv
// ----------------------------------------------------------------------------
// Simeck64 package
// Constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package simeck64_pkg;

    localparam int ROUNDS      = 44;
    localparam int RND_W       = $clog2(ROUNDS);
    localparam int KEY_IDX_W   = 6;
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = 64;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 64;

    localparam int IDX_LSB     = 0;
    localparam int SUBKEY_LSB  = IDX_LSB + KEY_IDX_W;
    localparam int BLOCK_LSB   = SUBKEY_LSB + WORD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2
    } cmd_t;

    typedef struct packed {
        logic start;
        logic decrypt;
        logic load;
        logic round_en;
        logic step_addr;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/simeck64_ctrl.sv
// ----------------------------------------------------------------------------
// Simeck64 controller
// Accepts transactions, sequences the rounds and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "simeck64_block_cipher_core_assert.svh"

module simeck64_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic [simeck64_pkg::CMD_W-1:0] s_cmd,
    output logic                          s_ready,
    input  wire simeck64_pkg::dp_sts_t    sts,
    output simeck64_pkg::ctrl_cmd_t       cmd
);
    import simeck64_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    state_t           state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_LOAD: begin
                            cmd.load = 1'b1;
                        end
                        CMD_ENCRYPT, CMD_DECRYPT: begin
                            cmd.start   = 1'b1;
                            cmd.decrypt = (s_cmd == CMD_DECRYPT);
                            cnt_next    = '0;
                            state_next  = ST_ROUND;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                cmd.round_en  = 1'b1;
                cmd.step_addr = (cnt_reg != LAST_RND);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_RND) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `SIMECK_ASSERT(a_onehot_state, aclk, aresetn, $onehot(state_reg), "state not one-hot")
    `SIMECK_ASSERT(a_finish_free, aclk, aresetn, cmd.finish |-> sts.out_free, "result overrun")
    `SIMECK_ASSERT(a_start_round, aclk, aresetn, cmd.start |=> (state_reg == ST_ROUND), "no round after start")
    `SIMECK_ASSERT(a_last_round, aclk, aresetn, (cmd.round_en && !cmd.step_addr) |=> (state_reg == ST_DONE), "round count mismatch")

endmodule

`default_nettype wire

>>> rtl/core/simeck64_dp.sv
// ----------------------------------------------------------------------------
// Simeck64 datapath
// Subkey memory, round register pair with one round unit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module simeck64_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire simeck64_pkg::ctrl_cmd_t           cmd,
    output simeck64_pkg::dp_sts_t                  sts,
    input  wire logic [simeck64_pkg::KEY_IDX_W-1:0] key_index,
    input  wire logic [simeck64_pkg::WORD_W-1:0]    subkey_value,
    input  wire logic [simeck64_pkg::BLOCK_W-1:0]   block_in,
    output logic      [simeck64_pkg::BLOCK_W-1:0]   block_out,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);
    import simeck64_pkg::*;

    localparam logic [RND_W-1:0]   FIRST_DEC = RND_W'(ROUNDS - 1);
    localparam logic [KEY_IDX_W:0] DEPTH     = (KEY_IDX_W + 1)'(ROUNDS);

    logic [WORD_W-1:0]  key_mem [ROUNDS];
    logic [WORD_W-1:0]  key_q_reg;
    logic [RND_W-1:0]   kaddr_reg;
    logic [RND_W-1:0]   rd_addr;
    logic               dir_reg;
    logic [WORD_W-1:0]  l_reg, l_next;
    logic [WORD_W-1:0]  r_reg, r_next;
    logic [WORD_W-1:0]  l_round;
    logic [BLOCK_W-1:0] out_reg;
    logic               out_valid_reg, out_valid_next;
    logic               wr_en;

    assign wr_en = cmd.load && ({1'b0, key_index} < DEPTH);

    always_comb begin
        if (cmd.start) begin
            rd_addr = cmd.decrypt ? FIRST_DEC : '0;
        end else if (cmd.step_addr) begin
            rd_addr = dir_reg ? (kaddr_reg - 1'b1) : (kaddr_reg + 1'b1);
        end else begin
            rd_addr = kaddr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[key_index[RND_W-1:0]] <= subkey_value;
        end
        key_q_reg <= key_mem[rd_addr];
    end

    assign l_round = (l_reg & {l_reg[WORD_W-6:0], l_reg[WORD_W-1:WORD_W-5]})
                   ^ {l_reg[WORD_W-2:0], l_reg[WORD_W-1]}
                   ^ r_reg ^ key_q_reg;

    always_comb begin
        l_next = l_reg;
        r_next = r_reg;
        if (cmd.start) begin
            l_next = cmd.decrypt ? block_in[WORD_W-1:0] : block_in[BLOCK_W-1:WORD_W];
            r_next = cmd.decrypt ? block_in[BLOCK_W-1:WORD_W] : block_in[WORD_W-1:0];
        end else if (cmd.round_en) begin
            l_next = l_round;
            r_next = l_reg;
        end
    end

    always_ff @(posedge aclk) begin
        kaddr_reg <= rd_addr;
        l_reg     <= l_next;
        r_reg     <= r_next;
        if (cmd.start) begin
            dir_reg <= cmd.decrypt;
        end
        if (cmd.finish) begin
            out_reg <= dir_reg ? {r_reg, l_reg} : {l_reg, r_reg};
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign block_out    = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/simeck64_block_cipher_core.sv
// ----------------------------------------------------------------------------
// Simeck64 block cipher core
// Simeck64/128 with 44 rounds and externally loaded round subkeys.
// ----------------------------------------------------------------------------
// An encrypt or decrypt transaction runs in steps: the accepting cycle latches
// the block and primes the subkey memory read, the rounds run on the single
// shared round unit (one round per cycle, fed by one read port of the subkey
// memory), and a final step hands the result to the output register. The
// hand-off step repeats while an earlier result still waits unaccepted on the
// output side. The next transaction is accepted while a result waits on the
// output side. Subkey entries must be loaded before a block uses them.
`default_nettype none

module simeck64_block_cipher_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [5:0] key_index, [37:6] subkey_value, [101:38] block_in, [103:102] zero
    input  wire logic [simeck64_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  wire logic [simeck64_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [63:0] block_out
    output logic      [simeck64_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import simeck64_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    simeck64_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_cmd   (s_axis_tuser),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    simeck64_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .key_index    (s_axis_tdata[IDX_LSB +: KEY_IDX_W]),
        .subkey_value (s_axis_tdata[SUBKEY_LSB +: WORD_W]),
        .block_in     (s_axis_tdata[BLOCK_LSB +: BLOCK_W]),
        .block_out    (m_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready)
    );

endmodule

`default_nettype wire

>>> test/simeck64_block_checker.sv
// ----------------------------------------------------------------------------
// Simeck64 block cipher checker
// Watches both stream channels of the core, mirrors the subkey table from
// accepted load transactions, computes the expected block for every accepted
// encrypt or decrypt transaction, and compares each result in order.
// ----------------------------------------------------------------------------
module simeck64_block_checker
    import simeck64_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // [5:0] key_index, [37:6] subkey_value, [101:38] block_in, [103:102] zero
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]       s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [63:0] block_out
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0]  subkeys [ROUNDS];
    logic [BLOCK_W-1:0] pending_blocks [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        for (int i = 0; i < ROUNDS; i++) subkeys[i] = '0;
    end

    function automatic logic [BLOCK_W-1:0] simeck_block(input logic decrypt,
                                                        input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] lw, rw, nl;
        int k;
        lw = decrypt ? blk[WORD_W-1:0] : blk[BLOCK_W-1:WORD_W];
        rw = decrypt ? blk[BLOCK_W-1:WORD_W] : blk[WORD_W-1:0];
        for (int n = 0; n < ROUNDS; n++) begin
            k  = decrypt ? ROUNDS - 1 - n : n;
            nl = (lw & {lw[26:0], lw[31:27]}) ^ {lw[30:0], lw[31]} ^ rw ^ subkeys[k];
            rw = lw;
            lw = nl;
        end
        return decrypt ? {rw, lw} : {lw, rw};
    endfunction

    always @(posedge aclk) begin
        logic [KEY_IDX_W-1:0] idx;
        logic [BLOCK_W-1:0]   blk, want;
        int                   errs;
        errs = 0;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_blocks.size() == 0) begin
                    $error("block_out: expected none, actual %h", m_axis_tdata);
                    errs++;
                end else begin
                    want = pending_blocks.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("block_out: expected %h, actual %h", want, m_axis_tdata);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                idx = s_axis_tdata[IDX_LSB +: KEY_IDX_W];
                blk = s_axis_tdata[BLOCK_LSB +: BLOCK_W];
                case (s_axis_tuser)
                    CMD_LOAD: begin
                        if (idx < ROUNDS) subkeys[idx] = s_axis_tdata[SUBKEY_LSB +: WORD_W];
                    end
                    CMD_ENCRYPT: pending_blocks.push_back(simeck_block(1'b0, blk));
                    CMD_DECRYPT: pending_blocks.push_back(simeck_block(1'b1, blk));
                    default: ;
                endcase
            end
        end
        mismatches  <= mismatches + errs;
        outstanding <= pending_blocks.size();
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Simeck64 block cipher core testbench
// Fills the subkey table, runs a directed set of blocks and corner commands, then a
// long random mix of encrypt, decrypt, subkey reload and ignored transactions with
// random gaps on both channels but for one gap-free stretch; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
    import simeck64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               IDLE_LIMIT  = 2000;
    localparam int               ITEM_COUNT  = 540;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = CMD_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  no_gaps       = 1'b0;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles   = 0;

    simeck64_block_cipher_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    simeck64_block_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 8);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] key, input logic [BLOCK_W-1:0] blk);
        while (!no_gaps && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, blk, key, idx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    function automatic logic [BLOCK_W-1:0] rand_block();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int counted;
        int pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every subkey before any block reads the table
        for (int i = 0; i < ROUNDS; i++) begin
            send_item(CMD_LOAD, i[KEY_IDX_W-1:0],
                      (i == 0) ? 32'h0 : (i == ROUNDS - 1) ? 32'hFFFF_FFFF : $urandom,
                      rand_block());
        end

        send_item(CMD_ENCRYPT, 6'd0,  32'h0,        64'h0);
        send_item(CMD_ENCRYPT, 6'd63, 32'hFFFF_FFFF, {BLOCK_W{1'b1}});
        send_item(CMD_DECRYPT, 6'd0,  32'h0,        64'h0);
        send_item(CMD_DECRYPT, 6'd63, 32'hFFFF_FFFF, {BLOCK_W{1'b1}});
        send_item(CMD_ENCRYPT, 6'd21, $urandom,     64'h0123_4567_89AB_CDEF);
        send_item(CMD_DECRYPT, 6'd42, $urandom,     64'h0123_4567_89AB_CDEF);
        send_item(CMD_LOAD,    6'd44, 32'hFFFF_FFFF, rand_block());
        send_item(CMD_LOAD,    6'd63, $urandom,     rand_block());
        send_item(CMD_UNUSED,  6'($urandom), $urandom, rand_block());
        send_item(CMD_ENCRYPT, 6'd0,  32'h0,        64'h0);
        send_item(CMD_LOAD,    6'd0,  32'hFFFF_FFFF, 64'h0);
        send_item(CMD_LOAD,    6'd43, 32'h0,        {BLOCK_W{1'b1}});
        send_item(CMD_ENCRYPT, 6'd0,  32'h0,        {BLOCK_W{1'b1}});
        send_item(CMD_DECRYPT, 6'd0,  32'h0,        64'h8000_0000_0000_0001);
        send_item(CMD_ENCRYPT, 6'd0,  32'h0,        64'h0000_0001_8000_0000);
        send_item(CMD_DECRYPT, 6'd0,  32'h0,        64'hAAAA_AAAA_5555_5555);

        counted = 0;
        while (counted < ITEM_COUNT) begin
            no_gaps = (counted >= 250) && (counted < 400);
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_item(CMD_ENCRYPT, 6'($urandom), $urandom, rand_block());
            end else if (pick < 60) begin
                send_item(CMD_DECRYPT, 6'($urandom), $urandom, rand_block());
            end else if (pick < 85) begin
                send_item(CMD_LOAD, 6'($urandom_range(ROUNDS - 1)), $urandom, rand_block());
            end else if (pick < 93) begin
                send_item(CMD_LOAD, 6'($urandom_range(63, ROUNDS)), $urandom, rand_block());
            end else begin
                send_item(CMD_UNUSED, 6'($urandom), $urandom, rand_block());
            end
            counted++;
        end
        no_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
